[rtl/core/ptsch_pkg.sv]
// Package with the types and codes shared by the periodic timer scheduler files.
package ptsch_pkg;

    localparam int TIME_W   = 40;
    localparam int PERIOD_W = 32;
    localparam int IDENT_W  = 32;
    localparam int REQ_W    = 2;
    localparam int KIND_W   = 3;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 160;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REFUSED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd5;

    typedef enum logic [1:0] {
        MODE_DUE    = 2'd0,
        MODE_PICK   = 2'd1,
        MODE_MIN    = 2'd2,
        MODE_CANCEL = 2'd3
    } scan_mode_t;

    typedef struct packed {
        logic                repeat_flag;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   deadline;
        logic [TIME_W-1:0]   last_handled;
        logic [IDENT_W-1:0]  ident;
    } slot_entry_t;

endpackage

[rtl/core/periodic_timer_scheduler.sv]
// Periodic timer scheduler: slot table in a synchronous memory with a scanning sequencer.
//
// Requests arrive on the s_ channel (tuser = request type, tdata = request fields) and
// results leave on the m_ channel (tuser = result kind, tlast on the final word of a run).
// An add answers with one word. A cancel scans the slot memory once and then answers with
// one word. A tick with F fires takes F + 3 full scans of the slot memory: a scan to mark
// due timers, one scan per fire plus a final empty one to find timers in deadline order,
// and one scan for the earliest remaining deadline. Every scan reads the slots through
// the single read port of the slot memory.
// A new request is taken only when the previous one has issued all its words; the last
// word may still sit in the output register while the next request is taken.
// Reset clears the active and pending flags and the id counter; the slot memory itself
// needs no clearing because an entry is only used once its slot has been written.
// When the receiver stalls, the output register holds its word and the sequencer waits.
module periodic_timer_scheduler
    import ptsch_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_time[39:0], period[71:40], repeat_req[72], cancel_id[104:73], zero pad.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0].
    input  logic [REQ_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // timer_id[31:0], fire_time[71:32], elapsed[111:72], has_waiting[112],
    // next_deadline[152:113], zero pad.
    output logic [OUT_DATA_W-1:0] m_tdata,
    // result_kind[2:0].
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ADD    = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_FIRE   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    scan_mode_t          mode_reg, mode_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                repeat_reg, repeat_next;
    logic [IDENT_W-1:0]  cid_reg, cid_next;
    logic [SLOTS-1:0]    active_reg, active_next;
    logic [SLOTS-1:0]    pending_reg, pending_next;
    logic [SLOTS-1:0]    due_reg, due_next;
    logic [IDENT_W-1:0]  ident_reg, ident_next;
    logic [CW-1:0]       rd_cnt_reg, rd_cnt_next;
    logic                proc_vld_reg, proc_vld_next;
    logic [IW-1:0]       proc_idx_reg, proc_idx_next;
    logic                found_reg, found_next;
    slot_entry_t         best_reg, best_next;
    logic [IW-1:0]       best_idx_reg, best_idx_next;

    logic                m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]   o_kind_reg, o_kind_next;
    logic [IDENT_W-1:0]  o_id_reg, o_id_next;
    logic [TIME_W-1:0]   o_ft_reg, o_ft_next;
    logic [TIME_W-1:0]   o_el_reg, o_el_next;
    logic                o_hw_reg, o_hw_next;
    logic [TIME_W-1:0]   o_nd_reg, o_nd_next;
    logic                o_last_reg, o_last_next;

    slot_entry_t         mem [SLOTS];
    slot_entry_t         rd_data_reg;
    logic                mem_we;
    logic [IW-1:0]       mem_wa;
    slot_entry_t         mem_wd;

    logic                out_free;
    logic                free_any;
    logic [IW-1:0]       free_idx;
    logic                take;
    logic [TIME_W:0]     add_sum;
    logic [TIME_W-1:0]   add_dl;
    logic [TIME_W:0]     rearm_sum;
    logic [TIME_W-1:0]   rearm_dl;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {7'd0, o_nd_reg, o_hw_reg, o_el_reg, o_ft_reg, o_id_reg};
    assign out_free = !m_valid_reg || m_tready;

    assign add_sum   = {1'b0, now_reg} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, period_reg};
    assign add_dl    = add_sum[TIME_W] ? {TIME_W{1'b1}} : add_sum[TIME_W-1:0];
    assign rearm_sum = {1'b0, now_reg} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, best_reg.period};
    assign rearm_dl  = rearm_sum[TIME_W] ? {TIME_W{1'b1}} : rearm_sum[TIME_W-1:0];

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!active_reg[i] && !pending_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_cnt_reg[IW-1:0]];
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        req_next      = req_reg;
        now_next      = now_reg;
        period_next   = period_reg;
        repeat_next   = repeat_reg;
        cid_next      = cid_reg;
        active_next   = active_reg;
        pending_next  = pending_reg;
        due_next      = due_reg;
        ident_next    = ident_reg;
        rd_cnt_next   = rd_cnt_reg;
        proc_vld_next = 1'b0;
        proc_idx_next = proc_idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        o_kind_next   = o_kind_reg;
        o_id_next     = o_id_reg;
        o_ft_next     = o_ft_reg;
        o_el_next     = o_el_reg;
        o_hw_next     = o_hw_reg;
        o_nd_next     = o_nd_reg;
        o_last_next   = o_last_reg;
        mem_we        = 1'b0;
        mem_wa        = best_idx_reg;
        mem_wd        = best_reg;
        take          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next    = s_tuser;
                    now_next    = s_tdata[39:0];
                    period_next = s_tdata[71:40];
                    repeat_next = s_tdata[72];
                    cid_next    = s_tdata[104:73];
                    rd_cnt_next = '0;
                    found_next  = 1'b0;
                    priority case (s_tuser)
                        REQ_ADD:
                        begin
                            state_next = ST_ADD;
                        end
                        REQ_TICK:
                        begin
                            due_next   = '0;
                            mode_next  = MODE_DUE;
                            state_next = ST_SCAN;
                        end
                        REQ_CANCEL:
                        begin
                            mode_next  = MODE_CANCEL;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ADD:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    o_ft_next    = '0;
                    o_el_next    = '0;
                    o_hw_next    = 1'b0;
                    o_nd_next    = '0;
                    o_last_next  = 1'b1;
                    if (free_any)
                    begin
                        mem_we                 = 1'b1;
                        mem_wa                 = free_idx;
                        mem_wd.repeat_flag     = repeat_reg;
                        mem_wd.period          = period_reg;
                        mem_wd.deadline        = add_dl;
                        mem_wd.last_handled    = now_reg;
                        mem_wd.ident           = ident_reg;
                        pending_next[free_idx] = 1'b1;
                        ident_next             = ident_reg + 1'b1;
                        o_kind_next            = KIND_ADDED;
                        o_id_next              = ident_reg;
                    end
                    else
                    begin
                        o_kind_next = KIND_REFUSED;
                        o_id_next   = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (rd_cnt_reg < CW'(SLOTS))
                begin
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                    proc_vld_next = 1'b1;
                    proc_idx_next = rd_cnt_reg[IW-1:0];
                end
                if (proc_vld_reg)
                begin
                    unique case (mode_reg)
                        MODE_DUE:
                        begin
                            due_next[proc_idx_reg] = active_reg[proc_idx_reg]
                                && (rd_data_reg.deadline <= now_reg);
                        end
                        MODE_PICK:
                        begin
                            take = due_reg[proc_idx_reg] && (!found_reg
                                || (rd_data_reg.deadline < best_reg.deadline)
                                || ((rd_data_reg.deadline == best_reg.deadline)
                                    && (rd_data_reg.ident < best_reg.ident)));
                        end
                        MODE_MIN:
                        begin
                            take = active_reg[proc_idx_reg] && (!found_reg
                                || (rd_data_reg.deadline < best_reg.deadline));
                        end
                        MODE_CANCEL:
                        begin
                            take = !found_reg
                                && (active_reg[proc_idx_reg] || pending_reg[proc_idx_reg])
                                && (rd_data_reg.ident == cid_reg);
                        end
                        default:
                        begin
                            take = 1'b0;
                        end
                    endcase
                    if (take)
                    begin
                        found_next    = 1'b1;
                        best_next     = rd_data_reg;
                        best_idx_next = proc_idx_reg;
                    end
                    if (proc_idx_reg == IW'(SLOTS - 1))
                    begin
                        rd_cnt_next   = '0;
                        proc_vld_next = 1'b0;
                        unique case (mode_reg)
                            MODE_DUE:
                            begin
                                mode_next  = MODE_PICK;
                                found_next = 1'b0;
                            end
                            MODE_PICK:
                            begin
                                if (found_next)
                                begin
                                    state_next = ST_FIRE;
                                end
                                else
                                begin
                                    active_next  = active_reg | pending_reg;
                                    pending_next = '0;
                                    mode_next    = MODE_MIN;
                                end
                            end
                            default:
                            begin
                                state_next = ST_FINISH;
                            end
                        endcase
                    end
                end
            end

            ST_FIRE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    o_kind_next  = KIND_FIRED;
                    o_id_next    = best_reg.ident;
                    o_ft_next    = now_reg;
                    o_el_next    = now_reg - best_reg.last_handled;
                    o_hw_next    = 1'b0;
                    o_nd_next    = '0;
                    o_last_next  = 1'b0;
                    due_next[best_idx_reg] = 1'b0;
                    if (best_reg.repeat_flag)
                    begin
                        mem_we              = 1'b1;
                        mem_wd.deadline     = rearm_dl;
                        mem_wd.last_handled = now_reg;
                    end
                    else
                    begin
                        active_next[best_idx_reg] = 1'b0;
                    end
                    found_next  = 1'b0;
                    rd_cnt_next = '0;
                    mode_next   = MODE_PICK;
                    state_next  = ST_SCAN;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    o_ft_next    = '0;
                    o_el_next    = '0;
                    o_last_next  = 1'b1;
                    if (req_reg == REQ_TICK)
                    begin
                        o_kind_next = KIND_TICK_DONE;
                        o_id_next   = '0;
                        o_hw_next   = found_reg;
                        o_nd_next   = found_reg ? best_reg.deadline : '0;
                    end
                    else
                    begin
                        o_id_next = cid_reg;
                        o_hw_next = 1'b0;
                        o_nd_next = '0;
                        if (found_reg)
                        begin
                            o_kind_next                = KIND_CANCELLED;
                            active_next[best_idx_reg]  = 1'b0;
                            pending_next[best_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            o_kind_next = KIND_NOT_FOUND;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_DUE;
            active_reg   <= '0;
            pending_reg  <= '0;
            due_reg      <= '0;
            ident_reg    <= '0;
            rd_cnt_reg   <= '0;
            proc_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            active_reg   <= active_next;
            pending_reg  <= pending_next;
            due_reg      <= due_next;
            ident_reg    <= ident_next;
            rd_cnt_reg   <= rd_cnt_next;
            proc_vld_reg <= proc_vld_next;
            found_reg    <= found_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        now_reg      <= now_next;
        period_reg   <= period_next;
        repeat_reg   <= repeat_next;
        cid_reg      <= cid_next;
        proc_idx_reg <= proc_idx_next;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        o_kind_reg   <= o_kind_next;
        o_id_reg     <= o_id_next;
        o_ft_reg     <= o_ft_next;
        o_el_reg     <= o_el_next;
        o_hw_reg     <= o_hw_next;
        o_nd_reg     <= o_nd_next;
        o_last_reg   <= o_last_next;
    end

endmodule

[rtl/core/ptsch_checker.sv]
// Port-level checker for the periodic timer scheduler and its bind statement.
module ptsch_checker
    import ptsch_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]     m_tuser,
    input logic                  m_tlast
);

    // A held word stays on the bus until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    // A fire is never the last word of a tick.
    a_fire_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_FIRED) |-> !m_tlast)
        else $error("fire word marked as last");

    // Every other result kind closes its run.
    a_other_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_FIRED) |-> m_tlast)
        else $error("closing word without last");

    // A refused add carries no id and a tick summary without waiting timers no deadline.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_REFUSED
            || (m_tuser == KIND_TICK_DONE && !m_tdata[112]))
        |-> (m_tdata[31:0] == 32'd0) && (m_tdata[152:113] == 40'd0))
        else $error("unexpected nonzero field");

endmodule

bind periodic_timer_scheduler ptsch_checker u_ptsch_checker (.*);
